[rtl/pag_pkg.sv]
`timescale 1ns / 1ps
package pag_pkg;
  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DEG_W     = 16;
  localparam int TOT_W     = 21;
  localparam int DIV_W     = TOT_W + 1;
  localparam int WORD_W    = 32;
  localparam int NC_W      = 11;
  localparam int MD_W      = 10;
  localparam int OUT_W     = 10;

  typedef struct packed {
    logic              valid;
    logic [DIV_W-1:0]  rem;
    logic [WORD_W-1:0] word;
    logic [DIV_W-1:0]  divisor;
  } div_cell_t;

  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] rem;
  } div_res_t;
endpackage

[rtl/preferential_attachment_graph_gen.sv]
`timescale 1ns / 1ps
// channel   dir  signals                       contents
// s_axis    in   tvalid tready tdata tuser     tdata: random_word; tuser: kind
// m_axis    out  tvalid tready tdata tlast     tdata: fields; tlast: node_done
// cfg       in   cfg_we cfg_index cfg_data     0 node_count, 1 mean_degree
// Start item: a mark clear sweep (which also seeds when the config is good) runs from accept to result.
// Draw item: the divider chain, the degree walk and the mark check, and on the finishing
// pick the commit sweep and append; with no graph or a done graph the result comes at once.
// Reset runs a mark clear sweep over all MAX_NODES entries; no item is taken meanwhile.
// One item at a time; a waiting result holds off the next item.
module preferential_attachment_graph_gen (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // random_word
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // new_node, target_node, accepted,
                                      // graph_done, config_error, zero pad
  output logic        m_axis_tlast,   // node_done
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import pag_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_MARK   = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;
  localparam logic [2:0] S_APPEND = 3'd7;
  localparam logic       KIND_START = 1'b0;
  localparam logic       REG_NODE_COUNT = 1'b0;

  logic [2:0]       state;
  logic [NC_W-1:0]  node_count;
  logic [MD_W-1:0]  mean_degree;
  logic [NC_W-1:0]  held_count;
  logic [MD_W-1:0]  held_degree;
  logic [CNT_W-1:0] current_node;
  logic [MD_W-1:0]  picks_made;
  logic [TOT_W-1:0] degree_total;
  logic [CNT_W-1:0] cnt;
  logic             seeding;
  logic             emit_pending;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [DIV_W-1:0] r;
  logic [DIV_W-1:0] acc;
  logic [IDX_W-1:0] tgt;

  logic [DEG_W-1:0] deg_mem [0:MAX_NODES-1];
  logic             mark_mem [0:MAX_NODES-1];
  logic [DEG_W-1:0] deg_q;
  logic             mark_q;
  logic [IDX_W-1:0] raddr;
  logic             deg_we, mark_we, mark_wd;
  logic [IDX_W-1:0] deg_wa, mark_wa;
  logic [DEG_W-1:0] deg_wd;

  logic [OUT_W-1:0] o_new, o_tgt;
  logic             o_acc, o_nd, o_gd, o_ce;

  div_cell_t div_req;
  div_res_t  div_res;

  logic             bad;
  logic [DIV_W-1:0] walk_sum;
  logic [CNT_W-1:0] last_idx;
  logic [MD_W-1:0]  picks_inc;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata  = {1'b0, o_ce, o_gd, o_acc, o_tgt, o_new};
  assign m_axis_tlast  = o_nd;

  assign bad = mean_degree[0] || (mean_degree < MD_W'(4)) ||
               ({21'd0, node_count} > 32'(MAX_NODES)) ||
               ({1'b0, mean_degree} + NC_W'(1) > node_count);
  assign walk_sum  = acc + DIV_W'(deg_q);
  assign last_idx  = current_node - CNT_W'(1);
  assign picks_inc = picks_made + MD_W'(1);

  pag_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  always_comb begin
    div_req.valid   = (state == S_IDLE) && s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser != KIND_START) && (current_node != '0) &&
                      (current_node < CNT_W'(held_count));
    div_req.rem     = '0;
    div_req.word    = s_axis_tdata;
    div_req.divisor = {1'b0, degree_total} + DIV_W'(1);
  end

  always_comb begin
    raddr   = (state == S_MARK) ? tgt : cnt[IDX_W-1:0];
    deg_we  = 1'b0;
    deg_wa  = rd_idx;
    deg_wd  = (deg_q == '1) ? deg_q : deg_q + DEG_W'(1);
    mark_we = 1'b0;
    mark_wa = rd_idx;
    mark_wd = 1'b0;
    case (state)
      S_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = cnt[IDX_W-1:0];
        deg_we  = seeding && (cnt <= CNT_W'(held_degree));
        deg_wa  = cnt[IDX_W-1:0];
        deg_wd  = DEG_W'(held_degree);
      end
      S_CHECK: begin
        mark_we = !mark_q;
        mark_wa = tgt;
        mark_wd = 1'b1;
      end
      S_COMMIT: begin
        deg_we  = rd_vld && mark_q;
        mark_we = rd_vld && mark_q;
      end
      S_APPEND: begin
        deg_we = 1'b1;
        deg_wa = current_node[IDX_W-1:0];
        deg_wd = DEG_W'(held_degree[MD_W-1:1]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    deg_q  <= deg_mem[raddr];
    mark_q <= mark_mem[raddr];
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      node_count    <= NC_W'(1024);
      mean_degree   <= MD_W'(4);
      held_count    <= '0;
      held_degree   <= '0;
      current_node  <= '0;
      picks_made    <= '0;
      degree_total  <= '0;
      cnt           <= '0;
      seeding       <= 1'b0;
      emit_pending  <= 1'b0;
      rd_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NODE_COUNT) begin
          node_count <= cfg_data;
        end else begin
          mean_degree <= cfg_data[MD_W-1:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAX_NODES - 1)) begin
            state         <= S_IDLE;
            m_axis_tvalid <= emit_pending;
            emit_pending  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            o_tgt <= '0;
            o_acc <= 1'b0;
            o_nd  <= 1'b0;
            if (s_axis_tuser == KIND_START) begin
              picks_made   <= '0;
              cnt          <= '0;
              emit_pending <= 1'b1;
              seeding      <= !bad;
              state        <= S_CLEAR;
              o_ce         <= bad;
              if (bad) begin
                current_node <= '0;
                degree_total <= '0;
                held_degree  <= '0;
                held_count   <= '0;
                o_new        <= '0;
                o_gd         <= 1'b0;
              end else begin
                held_degree  <= mean_degree;
                held_count   <= node_count;
                current_node <= CNT_W'(mean_degree) + CNT_W'(1);
                degree_total <= TOT_W'((NC_W'(mean_degree) + NC_W'(1)) *
                                       TOT_W'(mean_degree));
                o_new        <= OUT_W'(mean_degree + MD_W'(1));
                o_gd         <= (NC_W'(mean_degree) + NC_W'(1)) >= node_count;
              end
            end else begin
              o_new <= current_node[OUT_W-1:0];
              o_ce  <= 1'b0;
              o_gd  <= (current_node != '0) && (current_node >= CNT_W'(held_count));
              if ((current_node == '0) || (current_node >= CNT_W'(held_count))) begin
                m_axis_tvalid <= 1'b1;
              end else begin
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (div_res.valid) begin
            r      <= div_res.rem;
            acc    <= '0;
            cnt    <= '0;
            rd_vld <= 1'b0;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          cnt    <= cnt + CNT_W'(1);
          rd_idx <= cnt[IDX_W-1:0];
          if (rd_vld && (r < walk_sum)) begin
            tgt    <= rd_idx;
            o_tgt  <= OUT_W'(rd_idx);
            rd_vld <= 1'b0;
            state  <= S_MARK;
          end else if (rd_vld && (CNT_W'(rd_idx) == last_idx)) begin
            o_tgt         <= current_node[OUT_W-1:0];
            rd_vld        <= 1'b0;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end else begin
            rd_vld <= cnt < current_node;
            if (rd_vld) begin
              acc <= walk_sum;
            end
          end
        end
        S_MARK: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (mark_q) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end else begin
            o_acc <= 1'b1;
            if (picks_inc < MD_W'(held_degree[MD_W-1:1])) begin
              picks_made    <= picks_inc;
              m_axis_tvalid <= 1'b1;
              state         <= S_IDLE;
            end else begin
              o_nd   <= 1'b1;
              o_gd   <= (current_node + CNT_W'(1)) >= CNT_W'(held_count);
              cnt    <= '0;
              rd_vld <= 1'b0;
              state  <= S_COMMIT;
            end
          end
        end
        S_COMMIT: begin
          cnt    <= cnt + CNT_W'(1);
          rd_idx <= cnt[IDX_W-1:0];
          if (rd_vld && (CNT_W'(rd_idx) == last_idx)) begin
            rd_vld <= 1'b0;
            state  <= S_APPEND;
          end else begin
            rd_vld <= cnt < current_node;
          end
        end
        S_APPEND: begin
          degree_total  <= degree_total + TOT_W'(held_degree);
          current_node  <= current_node + CNT_W'(1);
          picks_made    <= '0;
          m_axis_tvalid <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/pag_div_cell.sv]
`timescale 1ns / 1ps
module pag_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  pag_pkg::div_cell_t din,
  output pag_pkg::div_cell_t dout
);
  import pag_pkg::*;

  logic [DIV_W:0] sh;
  logic [DIV_W:0] dv;

  assign sh = {din.rem, din.word[WORD_W-1]};
  assign dv = {1'b0, din.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.word    <= {din.word[WORD_W-2:0], 1'b0};
    dout.divisor <= din.divisor;
    if (sh >= dv) begin
      dout.rem <= DIV_W'(sh - dv);
    end else begin
      dout.rem <= DIV_W'(sh);
    end
  end
endmodule

[rtl/pag_div.sv]
`timescale 1ns / 1ps
module pag_div (
  input  logic               clk,
  input  logic               rst,
  input  pag_pkg::div_cell_t req,
  output pag_pkg::div_res_t  res
);
  import pag_pkg::*;

  div_cell_t link [0:WORD_W];

  assign link[0] = req;

  for (genvar i = 0; i < WORD_W; i++) begin : g_cell
    pag_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign res.valid = link[WORD_W].valid;
  assign res.rem   = link[WORD_W].rem;
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import pag_pkg::*;

  localparam bit KIND_START = 1'b0;
  localparam bit KIND_DRAW  = 1'b1;
  localparam bit REG_NODE_COUNT  = 1'b0;
  localparam bit REG_MEAN_DEGREE = 1'b1;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [9:0] new_node;
    logic [9:0] target_node;
    logic       accepted;
    logic       node_done;
    logic       graph_done;
    logic       config_error;
  } edge_result_t;

  typedef struct {
    bit        kind;
    bit [31:0] word;
    bit        aim_sum;
  } graph_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;

  preferential_attachment_graph_gen dut (.*);

  always #4 clk = ~clk;

  bit [15:0]   deg_tab [MAX_NODES];
  bit          marks [MAX_NODES];
  int unsigned cur_node, picks, deg_sum, nc_reg, md_reg, held_deg, held_cnt;

  graph_item_t  pending [$];
  edge_result_t expected_edges [$];
  graph_item_t  in_flight;
  int           send_idle, recv_idle, errors;
  longint       cycles;

  function automatic edge_result_t step_graph(bit kind, bit [31:0] word);
    edge_result_t res;
    int unsigned rv, run, tgt;
    bit found, bad;
    res = '0;
    if (kind == KIND_START) begin
      bad = md_reg[0] || md_reg < 4 || nc_reg > MAX_NODES || md_reg + 1 > nc_reg;
      foreach (marks[k]) marks[k] = 1'b0;
      picks = 0;
      if (bad) begin
        cur_node = 0; deg_sum = 0; held_deg = 0; held_cnt = 0;
        res.config_error = 1'b1;
        return res;
      end
      held_deg = md_reg;
      held_cnt = nc_reg;
      for (int k = 0; k <= md_reg; k++) deg_tab[k] = md_reg[15:0];
      cur_node = md_reg + 1;
      deg_sum = (md_reg + 1) * md_reg;
      res.new_node = cur_node[9:0];
      res.graph_done = cur_node >= held_cnt;
      return res;
    end
    res.new_node = cur_node[9:0];
    if (cur_node == 0) return res;
    if (cur_node >= held_cnt) begin
      res.graph_done = 1'b1;
      return res;
    end
    rv = word % (deg_sum + 1);
    tgt = cur_node;
    found = 1'b0;
    run = 0;
    for (int k = 0; k < cur_node && k < MAX_NODES; k++) begin
      if (rv < run + deg_tab[k]) begin
        tgt = k; found = 1'b1;
        break;
      end
      run += deg_tab[k];
    end
    res.target_node = tgt[9:0];
    if (!found || tgt >= MAX_NODES || marks[tgt]) return res;
    marks[tgt] = 1'b1;
    picks++;
    res.accepted = 1'b1;
    if (picks < held_deg / 2) return res;
    res.node_done = 1'b1;
    res.graph_done = cur_node + 1 >= held_cnt;
    for (int k = 0; k < cur_node && k < MAX_NODES; k++) begin
      if (marks[k]) begin
        if (deg_tab[k] != 16'hFFFF) deg_tab[k]++;
        marks[k] = 1'b0;
      end
    end
    if (cur_node < MAX_NODES) deg_tab[cur_node] = 16'(held_deg / 2);
    deg_sum = (deg_sum + held_deg) & 32'h1FFFFF;
    cur_node++;
    picks = 0;
    return res;
  endfunction

  always @(posedge clk) begin
    graph_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_edges.insert(expected_edges.size(),
                              step_graph(in_flight.kind, in_flight.word));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          it = pending.pop_front();
          if (it.aim_sum) it.word = deg_sum + (deg_sum + 1) * $urandom_range(0, 1000);
          in_flight = it;
          s_axis_tdata <= it.word;
          s_axis_tuser <= it.kind;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    edge_result_t got, want;
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.new_node = m_axis_tdata[9:0];
      got.target_node = m_axis_tdata[19:10];
      got.accepted = m_axis_tdata[20];
      got.graph_done = m_axis_tdata[21];
      got.config_error = m_axis_tdata[22];
      got.node_done = m_axis_tlast;
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = expected_edges.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add(bit kind, bit [31:0] word, bit aim_sum = 1'b0);
    graph_item_t it;
    it.kind = kind;
    it.word = word;
    it.aim_sum = aim_sum;
    pending.insert(pending.size(), it);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending.size() != 0 || s_axis_tvalid || expected_edges.size() != 0);
  endtask

  task automatic write_reg(bit idx, bit [10:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_NODE_COUNT) nc_reg = {21'd0, val};
    else md_reg = {22'd0, val[9:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_graph(int unsigned nc, int unsigned md);
    settle();
    write_reg(REG_NODE_COUNT, 11'(nc));
    write_reg(REG_MEAN_DEGREE, 11'(md));
  endtask

  initial begin
    int unsigned nc, md, draws;
    cycles = 0;
    errors = 0;
    nc_reg = 1024; md_reg = 4;
    send_idle = 26; recv_idle = 74;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add(KIND_DRAW, 32'h0);
    add(KIND_DRAW, $urandom);
    add(KIND_START, $urandom);
    add(KIND_DRAW, 32'h0);
    add(KIND_DRAW, 32'hFFFFFFFF);
    add(KIND_DRAW, 0, 1'b1);
    repeat (3) add(KIND_DRAW, $urandom);
    set_graph(1024, 1023);
    add(KIND_START, 0);
    add(KIND_DRAW, $urandom);
    set_graph(1024, 2);
    add(KIND_START, 0);
    set_graph(6, 6);
    add(KIND_START, 0);
    set_graph(2047, 4);
    add(KIND_START, 0);
    add(KIND_DRAW, $urandom);
    set_graph(1023, 1022);
    add(KIND_START, 0);
    add(KIND_DRAW, $urandom);
    set_graph(1024, 1022);
    add(KIND_START, 0);
    add(KIND_DRAW, 32'hFFFFFFFF);
    add(KIND_DRAW, 0, 1'b1);
    add(KIND_DRAW, $urandom);

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      if (ph < 4) begin
        send_idle = 26; recv_idle = 74;
      end else if (ph < 8) begin
        send_idle = 74; recv_idle = 26;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      if ($urandom_range(99) < 15) begin
        nc = $urandom_range(0, 2047);
        md = $urandom_range(0, 1023);
      end else begin
        nc = $urandom_range(6, 40);
        md = 2 * $urandom_range(2, (nc - 1) / 2);
      end
      set_graph(nc, md);
      add(KIND_START, $urandom);
      draws = $urandom_range(40, 48);
      for (int i = 0; i < draws; i++) begin
        case ($urandom_range(99)) inside
          [0:1]:   add(KIND_START, $urandom);
          [2:6]:   add(KIND_DRAW, 0, 1'b1);
          default: add(KIND_DRAW, $urandom);
        endcase
      end
    end

    settle();
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_edges.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/pag_pkg.sv
rtl/pag_div_cell.sv
rtl/pag_div.sv
rtl/preferential_attachment_graph_gen.sv
verif/tb.sv
